// ===== hw/rtl/gac_pkg.sv =====
// Shared types, constants and helpers for the glyph alpha compositor.
package gac_pkg;

    // Quotient width and divider slicing
    localparam int NUM_W      = 24;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = NUM_W / DIV_STEPS;

    typedef logic [2:0][7:0] color_t;
    typedef logic [3:0][7:0] pixel4_t;

    typedef struct packed {
        logic [7:0] coverage;
        logic [7:0] src_c0;
        logic [7:0] src_c1;
        logic [7:0] src_c2;
        logic [7:0] src_alpha;
        logic [7:0] dst_c0;
        logic [7:0] dst_c1;
        logic [7:0] dst_c2;
        logic [7:0] dst_alpha;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] out_c0;
        logic [7:0] out_c1;
        logic [7:0] out_c2;
        logic [7:0] out_alpha;
    } pixel_out_t;

    typedef enum logic [1:0] {
        MODE_GLYPH = 2'd0,
        MODE_OVER  = 2'd1,
        MODE_LERP  = 2'd2,
        MODE_PASS  = 2'd3
    } blend_mode_t;

    typedef enum logic [1:0] {
        CFG_BLEND_MODE    = 2'd0,
        CFG_GLYPH_COLOR   = 2'd1,
        CFG_YUV_OUTPUT    = 2'd2,
        CFG_MATRIX_SELECT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        blend_mode_t blend_mode;
        logic [31:0] glyph_color;
        logic        yuv_output;
        logic        matrix_select;
    } cfg_t;

    // How the final pixel is formed
    typedef enum logic [1:0] {
        KIND_COPY = 2'd0,
        KIND_KEEP = 2'd1,
        KIND_OVER = 2'd2,
        KIND_LERP = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        color_t                  sel;
        logic [7:0]              asel;
        pixel4_t                 dst;
        logic [2:0][NUM_W-1:0]   num;
        logic [7:0]              na;
    } front_out_t;

    typedef struct packed {
        logic                    use_div;
        logic [7:0]              na;
        logic [2:0][NUM_W-1:0]   quot;
        pixel_out_t              fb;
    } div_out_t;

    // (v + 255) >> 8, saturated at 255
    function automatic logic [7:0] round_sat(input logic [NUM_W-1:0] v);
        logic [NUM_W:0]   sum;
        logic [NUM_W-8:0] hi;
        sum = {1'b0, v} + (NUM_W+1)'(255);
        hi  = sum[NUM_W:8];
        return (hi > (NUM_W-7)'(255)) ? 8'hFF : hi[7:0];
    endfunction

endpackage

// ===== hw/rtl/gac_if.sv =====
// Stream interfaces for input pixel words and composited pixel words.
interface gac_pixel_if;
    logic                 valid;
    logic                 ready;
    gac_pkg::pixel_in_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gac_composite_if;
    logic                 valid;
    logic                 ready;
    gac_pkg::pixel_out_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gac_front.sv =====
// Front pipeline: glyph color conversion, alpha weights and blend numerators.
module gac_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  gac_pkg::cfg_t       cfg,
    input  logic                in_valid,
    input  gac_pkg::pixel_in_t  in_data,
    output logic                in_ready,
    output logic                out_valid,
    output gac_pkg::front_out_t out_data,
    input  logic                out_ready
);

    localparam logic [23:0] C601_YR = 24'd263;
    localparam logic [23:0] C601_YG = 24'd516;
    localparam logic [23:0] C601_YB = 24'd100;
    localparam logic [23:0] C601_UB = 24'd7168;
    localparam logic [23:0] C601_UR = 24'd2419;
    localparam logic [23:0] C601_UG = 24'd4749;
    localparam logic [23:0] C601_VR = 24'd448;
    localparam logic [23:0] C601_VG = 24'd375;
    localparam logic [23:0] C601_VB = 24'd73;
    localparam logic [23:0] C709_YR = 24'd745;
    localparam logic [23:0] C709_YG = 24'd2506;
    localparam logic [23:0] C709_YB = 24'd253;
    localparam logic [23:0] C709_UB = 24'd448;
    localparam logic [23:0] C709_UR = 24'd41;
    localparam logic [23:0] C709_UG = 24'd407;
    localparam logic [23:0] C709_VR = 24'd14336;
    localparam logic [23:0] C709_VG = 24'd11051;
    localparam logic [23:0] C709_VB = 24'd3285;
    localparam logic [23:0] OFS_10  = 24'd131072;
    localparam logic [23:0] OFS_14  = 24'd2097152;
    localparam logic [23:0] OFS_15  = 24'd4194304;
    localparam logic [23:0] LUMA_OFS = 24'd16;

    typedef struct packed {
        gac_pkg::pixel_in_t px;
        gac_pkg::color_t    col;
        logic [15:0]        cov_prod;
    } s1_t;

    typedef struct packed {
        gac_pkg::kind_t     kind;
        gac_pkg::color_t    sel;
        logic [7:0]         asel;
        gac_pkg::pixel4_t   dst;
        logic [15:0]        wa;
        logic [15:0]        wb;
    } s2_t;

    function automatic logic [7:0] sat8(input logic [23:0] v);
        return (v > 24'd255) ? 8'hFF : v[7:0];
    endfunction

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    gac_pkg::front_out_t s3_reg, s3_next;

    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s3_valid_reg;
    assign out_data  = s3_reg;

    // Stage 1: glyph color in the output space, coverage times glyph alpha
    always_comb
    begin
        logic [23:0] r24, g24, b24;
        logic [23:0] y_v, u_v, v_v;
        logic [7:0]  ga;
        r24 = {16'h0000, cfg.glyph_color[31:24]};
        g24 = {16'h0000, cfg.glyph_color[23:16]};
        b24 = {16'h0000, cfg.glyph_color[15:8]};
        ga  = ~cfg.glyph_color[7:0];
        if (cfg.matrix_select)
        begin
            y_v = ((C709_YR * r24 + C709_YG * g24 + C709_YB * b24) >> 12) + LUMA_OFS;
            u_v = (C709_UB * b24 + OFS_10 - C709_UR * r24 - C709_UG * g24) >> 10;
            v_v = (C709_VR * r24 + OFS_15 - C709_VG * g24 - C709_VB * b24) >> 15;
        end
        else
        begin
            y_v = ((C601_YR * r24 + C601_YG * g24 + C601_YB * b24) >> 10) + LUMA_OFS;
            u_v = (C601_UB * b24 + OFS_14 - C601_UR * r24 - C601_UG * g24) >> 14;
            v_v = (C601_VR * r24 + OFS_10 - C601_VG * g24 - C601_VB * b24) >> 10;
        end
        s1_next.px = in_data;
        if (cfg.yuv_output)
        begin
            s1_next.col[0] = sat8(y_v);
            s1_next.col[1] = sat8(u_v);
            s1_next.col[2] = sat8(v_v);
        end
        else
        begin
            s1_next.col[0] = cfg.glyph_color[15:8];
            s1_next.col[1] = cfg.glyph_color[23:16];
            s1_next.col[2] = cfg.glyph_color[31:24];
        end
        s1_next.cov_prod = {8'h00, in_data.coverage} * {8'h00, ga};
    end

    // Stage 2: pick the blend case and the two alpha weights
    always_comb
    begin
        logic [15:0] an_sum;
        logic [7:0]  an;
        logic [7:0]  inv_a;
        logic [15:0] wa_over;
        logic [15:0] wb_over;
        gac_pkg::color_t src;
        an_sum = s1_reg.cov_prod + 16'd255;
        an     = an_sum[15:8];
        src[0] = s1_reg.px.src_c0;
        src[1] = s1_reg.px.src_c1;
        src[2] = s1_reg.px.src_c2;
        s2_next.dst[0] = s1_reg.px.dst_c0;
        s2_next.dst[1] = s1_reg.px.dst_c1;
        s2_next.dst[2] = s1_reg.px.dst_c2;
        s2_next.dst[3] = s1_reg.px.dst_alpha;
        s2_next.sel    = src;
        s2_next.asel   = s1_reg.px.src_alpha;
        case (cfg.blend_mode)
            gac_pkg::MODE_GLYPH:
            begin
                s2_next.sel  = s1_reg.col;
                s2_next.asel = an;
                s2_next.kind = (s1_reg.px.dst_alpha == 8'h00 || an == 8'hFF)
                               ? gac_pkg::KIND_COPY : gac_pkg::KIND_OVER;
            end
            gac_pkg::MODE_OVER:
                s2_next.kind = (s1_reg.px.dst_alpha == 8'h00)
                               ? gac_pkg::KIND_COPY : gac_pkg::KIND_OVER;
            gac_pkg::MODE_LERP:
                s2_next.kind = gac_pkg::KIND_LERP;
            default:
                s2_next.kind = gac_pkg::KIND_KEEP;
        endcase
        inv_a   = ~s2_next.asel;
        wa_over = {s2_next.asel, 8'h00} - {8'h00, s2_next.asel};
        wb_over = {8'h00, s1_reg.px.dst_alpha} * {8'h00, inv_a};
        if (s2_next.kind == gac_pkg::KIND_LERP)
        begin
            s2_next.wa = {8'h00, s2_next.asel};
            s2_next.wb = {8'h00, inv_a};
        end
        else
        begin
            s2_next.wa = wa_over;
            s2_next.wb = wb_over;
        end
    end

    // Stage 3: weighted sums and the result alpha
    always_comb
    begin
        logic [15:0] na_sum;
        na_sum = s2_reg.wa + s2_reg.wb + 16'd255;
        s3_next.kind = s2_reg.kind;
        s3_next.sel  = s2_reg.sel;
        s3_next.asel = s2_reg.asel;
        s3_next.dst  = s2_reg.dst;
        s3_next.na   = na_sum[15:8];
        for (int k = 0; k < 3; k++)
        begin
            s3_next.num[k] = {8'h00, s2_reg.wa} * {16'h0000, s2_reg.sel[k]}
                           + {8'h00, s2_reg.wb} * {16'h0000, s2_reg.dst[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
            s1_reg <= s1_next;
        if (s2_ready)
            s2_reg <= s2_next;
        if (s3_ready)
            s3_reg <= s3_next;
    end

endmodule

// ===== hw/rtl/gac_div.sv =====
// Pipelined restoring divider: three numerators over the result alpha.
module gac_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  gac_pkg::front_out_t in_data,
    output logic                in_ready,
    output logic                out_valid,
    output gac_pkg::div_out_t   out_data,
    input  logic                out_ready
);

    localparam int NW   = gac_pkg::NUM_W;
    localparam int NST  = gac_pkg::DIV_STAGES;
    localparam int LAST = NST - 1;

    typedef struct packed {
        logic                 use_div;
        logic [7:0]           na;
        logic [2:0][7:0]      rem;
        logic [2:0][NW-1:0]   acc;
        gac_pkg::pixel_out_t  fb;
    } div_stage_t;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] stage_ready;
    logic [NST-1:0] prev_valid;
    div_stage_t     stage_reg  [NST];
    div_stage_t     stage_next [NST];
    div_stage_t     entry;

    // Entry: the pixel used when no division applies
    always_comb
    begin
        entry.use_div = (in_data.kind == gac_pkg::KIND_OVER) && (in_data.na != 8'h00);
        entry.na      = in_data.na;
        entry.rem     = '0;
        entry.acc     = in_data.num;
        entry.fb.out_c0    = in_data.dst[0];
        entry.fb.out_c1    = in_data.dst[1];
        entry.fb.out_c2    = in_data.dst[2];
        entry.fb.out_alpha = in_data.dst[3];
        case (in_data.kind)
            gac_pkg::KIND_COPY:
            begin
                entry.fb.out_c0    = in_data.sel[0];
                entry.fb.out_c1    = in_data.sel[1];
                entry.fb.out_c2    = in_data.sel[2];
                entry.fb.out_alpha = in_data.asel;
            end
            gac_pkg::KIND_LERP:
            begin
                entry.fb.out_c0 = gac_pkg::round_sat(in_data.num[0]);
                entry.fb.out_c1 = gac_pkg::round_sat(in_data.num[1]);
                entry.fb.out_c2 = gac_pkg::round_sat(in_data.num[2]);
            end
            gac_pkg::KIND_OVER:
                entry.fb.out_alpha = 8'h00;
            default:
                entry.fb.out_alpha = in_data.dst[3];
        endcase
    end

    // Each stage retires DIV_STEPS quotient bits per lane
    always_comb
    begin
        div_stage_t  st;
        logic [8:0]  trial;
        logic [8:0]  diff;
        for (int i = 0; i < NST; i++)
        begin
            st = (i == 0) ? entry : stage_reg[(i == 0) ? 0 : i - 1];
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < gac_pkg::DIV_STEPS; j++)
                begin
                    trial = {st.rem[k], st.acc[k][NW-1]};
                    diff  = trial - {1'b0, st.na};
                    if (trial >= {1'b0, st.na})
                    begin
                        st.rem[k] = diff[7:0];
                        st.acc[k] = {st.acc[k][NW-2:0], 1'b1};
                    end
                    else
                    begin
                        st.rem[k] = trial[7:0];
                        st.acc[k] = {st.acc[k][NW-2:0], 1'b0};
                    end
                end
            end
            stage_next[i] = st;
        end
    end

    always_comb
    begin
        stage_ready[LAST] = !valid_reg[LAST] || out_ready;
        for (int i = LAST - 1; i >= 0; i--)
            stage_ready[i] = !valid_reg[i] || stage_ready[i + 1];
    end

    assign prev_valid = {valid_reg[NST-2:0], in_valid};
    assign in_ready   = stage_ready[0];
    assign out_valid  = valid_reg[LAST];

    assign out_data.use_div = stage_reg[LAST].use_div;
    assign out_data.na      = stage_reg[LAST].na;
    assign out_data.quot    = stage_reg[LAST].acc;
    assign out_data.fb      = stage_reg[LAST].fb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (stage_ready[i])
                    valid_reg[i] <= prev_valid[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST; i++)
        begin
            if (stage_ready[i])
                stage_reg[i] <= stage_next[i];
        end
    end

`ifndef NO_ASSERTIONS
    // A finished quotient leaves a remainder below the divisor in every lane
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LAST] && stage_reg[LAST].use_div) |->
            (stage_reg[LAST].rem[0] < stage_reg[LAST].na) &&
            (stage_reg[LAST].rem[1] < stage_reg[LAST].na) &&
            (stage_reg[LAST].rem[2] < stage_reg[LAST].na))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== hw/rtl/glyph_alpha_composite_pixel.sv =====
// Top level of the glyph alpha compositor: config registers, pipeline, output register.
//
//   port       | dir  | word              | handshake
//   -----------+------+-------------------+--------------------------
//   pixel      | in   | pixel_in_t        | valid/ready
//   composite  | out  | pixel_out_t       | valid/ready
//   cfg_*      | in   | index + 32b data  | write enable, no wait
//
// One pixel per cycle while the output is not stalled, through ten register stages:
// three front stages, six divider stages (24 quotient bits, 4 per stage per lane,
// three lanes) and the output register.
// Reset clears all valid bits and the configuration registers.
// A stalled output holds its word; empty stages still fill behind it, and
// pixel.ready drops only once every stage holds a word.
module glyph_alpha_composite_pixel
(
    input  logic                 clk,
    input  logic                 rst_n,
    gac_pixel_if.sink            pixel,
    gac_composite_if.source      composite,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    gac_pkg::cfg_t       cfg_reg;
    logic                front_valid;
    logic                front_ready;
    gac_pkg::front_out_t front_out;
    logic                div_valid;
    logic                div_ready;
    gac_pkg::div_out_t   div_out;
    logic                out_valid_reg;
    gac_pkg::pixel_out_t out_reg, out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_mode    <= gac_pkg::MODE_GLYPH;
            cfg_reg.glyph_color   <= '0;
            cfg_reg.yuv_output    <= 1'b0;
            cfg_reg.matrix_select <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (gac_pkg::cfg_index_t'(cfg_index))
                gac_pkg::CFG_BLEND_MODE:
                    cfg_reg.blend_mode <= gac_pkg::blend_mode_t'(cfg_data[1:0]);
                gac_pkg::CFG_GLYPH_COLOR:
                    cfg_reg.glyph_color <= cfg_data;
                gac_pkg::CFG_YUV_OUTPUT:
                    cfg_reg.yuv_output <= cfg_data[0];
                gac_pkg::CFG_MATRIX_SELECT:
                    cfg_reg.matrix_select <= cfg_data[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    gac_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (pixel.valid),
        .in_data   (pixel.data),
        .in_ready  (pixel.ready),
        .out_valid (front_valid),
        .out_data  (front_out),
        .out_ready (front_ready)
    );

    gac_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_data   (front_out),
        .in_ready  (front_ready),
        .out_valid (div_valid),
        .out_data  (div_out),
        .out_ready (div_ready)
    );

    assign div_ready = !out_valid_reg || composite.ready;

    // Round the quotients, or take the pixel formed without division
    always_comb
    begin
        if (div_out.use_div)
        begin
            out_next.out_c0    = gac_pkg::round_sat(div_out.quot[0]);
            out_next.out_c1    = gac_pkg::round_sat(div_out.quot[1]);
            out_next.out_c2    = gac_pkg::round_sat(div_out.quot[2]);
            out_next.out_alpha = div_out.na;
        end
        else
            out_next = div_out.fb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (div_ready)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (div_ready)
            out_reg <= out_next;
    end

    assign composite.valid = out_valid_reg;
    assign composite.data  = out_reg;

`ifndef NO_ASSERTIONS
    // Over never lowers alpha below the source alpha and never yields zero
    a_over_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && front_out.kind == gac_pkg::KIND_OVER) |->
            (front_out.na >= front_out.asel) && (front_out.na != 8'h00))
        else $error("over result alpha below source alpha");

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && !front_ready) |=> front_valid && $stable(front_out))
        else $error("front word changed while stalled");

    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid && !div_ready) |=> div_valid && $stable(div_out))
        else $error("divider word changed while stalled");
`endif

endmodule
